// ----- design/wsd_pkg.sv -----
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants for the wiggle section decoder: header layout,
// section type codes, status codes, register indexes and the result record.
// ----------------------------------------------------------------------------
package wsd_pkg;

    // Section header layout (byte offsets within the 24-byte header)
    localparam int C_HDR_BYTES    = 24;
    localparam logic [4:0] C_HDR_LAST     = 5'(C_HDR_BYTES - 1);
    localparam logic [4:0] C_OFS_TYPE     = 5'd20;
    localparam logic [4:0] C_OFS_COUNT_LO = 5'd22;
    localparam logic [4:0] C_OFS_COUNT_HI = 5'd23;

    // Item sizes in bytes per section type
    localparam int C_BEDGRAPH_BYTES  = 12;
    localparam int C_VARSTEP_BYTES   = 8;
    localparam int C_FIXEDSTEP_BYTES = 4;

    // Section type codes
    localparam logic [7:0] TYPE_BEDGRAPH  = 8'd1;
    localparam logic [7:0] TYPE_VARSTEP   = 8'd2;
    localparam logic [7:0] TYPE_FIXEDSTEP = 8'd3;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TRUNCATED = 2'd1;
    localparam logic [1:0] ST_BAD_TYPE  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_QUERY_CHROM = 2'd0;
    localparam logic [1:0] REG_QUERY_START = 2'd1;
    localparam logic [1:0] REG_QUERY_END   = 2'd2;

    localparam int C_COORD_W = 49;

    typedef struct packed {
        logic [31:0] chrom;
        logic [31:0] start;
        logic [31:0] stop;
    } t_query;

    typedef struct packed {
        logic                   has_interval;
        logic [C_COORD_W-1:0]   interval_start;
        logic [C_COORD_W-1:0]   interval_end;
        logic [31:0]            value_bits;
        logic                   block_done;
        logic [1:0]             status;
        logic [31:0]            reported_count;
    } t_result;

    // Byte index of the final byte of one item
    function automatic logic [4:0] f_item_last(input logic [7:0] sect_type);
        logic [4:0] last_idx;
        case (sect_type)
            TYPE_BEDGRAPH: last_idx = 5'(C_BEDGRAPH_BYTES - 1);
            TYPE_VARSTEP:  last_idx = 5'(C_VARSTEP_BYTES - 1);
            default:       last_idx = 5'(C_FIXEDSTEP_BYTES - 1);
        endcase
        return last_idx;
    endfunction

endpackage

// ----- design/wsd_core.sv -----
// ----------------------------------------------------------------------------
// wsd_core
// Parse state and per-byte decode. Updates the section/item registers on each
// fired byte and presents the result of that byte combinationally.
// ----------------------------------------------------------------------------
module wsd_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic [7:0]          i_byte,
    input  logic                i_last,
    input  wsd_pkg::t_query     i_query,
    output logic                o_res_valid,
    output wsd_pkg::t_result    o_res
);
    import wsd_pkg::*;

    // Control state
    logic [4:0]           r_byte_index, n_byte_index;
    logic                 r_in_header, n_in_header;
    logic [15:0]          r_items_left, n_items_left;
    logic [31:0]          r_hit_count, n_hit_count;
    logic [1:0]           r_error, n_error;
    logic [C_COORD_W-1:0] r_fixed_next, n_fixed_next;

    // Payload state (every lane written before it is used)
    logic [31:0] r_sect_chrom, n_sect_chrom;
    logic [31:0] r_sect_start, n_sect_start;
    logic [31:0] r_sect_step, n_sect_step;
    logic [31:0] r_sect_span, n_sect_span;
    logic [7:0]  r_sect_type, n_sect_type;
    logic [31:0] r_field_a, n_field_a;
    logic [31:0] r_field_b, n_field_b;
    logic [31:0] r_field_c, n_field_c;

    logic                 hit;
    logic [C_COORD_W-1:0] item_s, item_e;
    logic [31:0]          item_v;
    logic [4:0]           lane_ofs;

    assign lane_ofs = {r_byte_index[1:0], 3'b000};

    // Next-state and result decode
    always_comb begin
        n_byte_index = r_byte_index;
        n_in_header  = r_in_header;
        n_items_left = r_items_left;
        n_hit_count  = r_hit_count;
        n_error      = r_error;
        n_fixed_next = r_fixed_next;
        n_sect_chrom = r_sect_chrom;
        n_sect_start = r_sect_start;
        n_sect_step  = r_sect_step;
        n_sect_span  = r_sect_span;
        n_sect_type  = r_sect_type;
        n_field_a    = r_field_a;
        n_field_b    = r_field_b;
        n_field_c    = r_field_c;
        hit          = 1'b0;
        item_s       = '0;
        item_e       = '0;
        item_v       = '0;

        if (r_error == ST_OK) begin
            if (r_in_header) begin
                // header bytes into their fields
                if (r_byte_index inside {[5'd0:5'd3]}) begin
                    n_sect_chrom[lane_ofs +: 8] = i_byte;
                end else if (r_byte_index inside {[5'd4:5'd7]}) begin
                    n_sect_start[lane_ofs +: 8] = i_byte;
                end else if (r_byte_index inside {[5'd12:5'd15]}) begin
                    n_sect_step[lane_ofs +: 8] = i_byte;
                end else if (r_byte_index inside {[5'd16:5'd19]}) begin
                    n_sect_span[lane_ofs +: 8] = i_byte;
                end else if (r_byte_index == C_OFS_TYPE) begin
                    n_sect_type = i_byte;
                end else if (r_byte_index == C_OFS_COUNT_LO) begin
                    n_items_left[7:0] = i_byte;
                end else if (r_byte_index == C_OFS_COUNT_HI) begin
                    n_items_left[15:8] = i_byte;
                end

                if (r_byte_index == C_HDR_LAST) begin
                    n_byte_index = '0;
                    if (n_items_left != 16'd0) begin
                        if (r_sect_type inside {TYPE_BEDGRAPH, TYPE_VARSTEP,
                                                TYPE_FIXEDSTEP}) begin
                            n_in_header  = 1'b0;
                            n_fixed_next = {{(C_COORD_W-32){1'b0}}, r_sect_start};
                        end else begin
                            n_error = ST_BAD_TYPE;
                        end
                    end
                end else begin
                    n_byte_index = r_byte_index + 5'd1;
                end
            end else begin
                // item bytes into field a/b/c
                if (r_byte_index inside {[5'd0:5'd3]}) begin
                    n_field_a[lane_ofs +: 8] = i_byte;
                end else if (r_byte_index inside {[5'd4:5'd7]}) begin
                    n_field_b[lane_ofs +: 8] = i_byte;
                end else begin
                    n_field_c[lane_ofs +: 8] = i_byte;
                end

                if (r_byte_index == f_item_last(r_sect_type)) begin
                    n_byte_index = '0;
                    case (r_sect_type)
                        TYPE_BEDGRAPH: begin
                            item_s = {{(C_COORD_W-32){1'b0}}, n_field_a};
                            item_e = {{(C_COORD_W-32){1'b0}}, n_field_b};
                            item_v = n_field_c;
                        end
                        TYPE_VARSTEP: begin
                            item_s = {{(C_COORD_W-32){1'b0}}, n_field_a};
                            item_e = {{(C_COORD_W-32){1'b0}}, n_field_a}
                                   + {{(C_COORD_W-32){1'b0}}, r_sect_span};
                            item_v = n_field_b;
                        end
                        default: begin
                            item_s = r_fixed_next;
                            item_e = r_fixed_next
                                   + {{(C_COORD_W-32){1'b0}}, r_sect_span};
                            item_v = n_field_a;
                            n_fixed_next = r_fixed_next
                                         + {{(C_COORD_W-32){1'b0}}, r_sect_step};
                        end
                    endcase
                    n_items_left = r_items_left - 16'd1;
                    if (n_items_left == 16'd0) begin
                        n_in_header = 1'b1;
                    end
                    // overlap test against the query
                    if ((r_sect_chrom == i_query.chrom) &&
                        (item_s < {{(C_COORD_W-32){1'b0}}, i_query.stop}) &&
                        (item_e > {{(C_COORD_W-32){1'b0}}, i_query.start})) begin
                        hit         = 1'b1;
                        n_hit_count = r_hit_count + 32'd1;
                    end
                end else begin
                    n_byte_index = r_byte_index + 5'd1;
                end
            end
        end

        // block ends while items are still owed
        if (i_last && (n_error == ST_OK) && !n_in_header) begin
            n_error = ST_TRUNCATED;
        end

        // result of this byte
        o_res_valid          = i_fire && (hit || i_last);
        o_res.has_interval   = hit;
        o_res.interval_start = hit ? item_s : '0;
        o_res.interval_end   = hit ? item_e : '0;
        o_res.value_bits     = hit ? item_v : '0;
        o_res.block_done     = i_last;
        o_res.status         = n_error;
        o_res.reported_count = n_hit_count;

        // end of block: back to the idle parse state
        if (i_last) begin
            n_byte_index = '0;
            n_in_header  = 1'b1;
            n_items_left = '0;
            n_hit_count  = '0;
            n_error      = ST_OK;
            n_fixed_next = '0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index <= '0;
            r_in_header  <= 1'b1;
            r_items_left <= '0;
            r_hit_count  <= '0;
            r_error      <= ST_OK;
            r_fixed_next <= '0;
        end else if (i_fire) begin
            r_byte_index <= n_byte_index;
            r_in_header  <= n_in_header;
            r_items_left <= n_items_left;
            r_hit_count  <= n_hit_count;
            r_error      <= n_error;
            r_fixed_next <= n_fixed_next;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_sect_chrom <= n_sect_chrom;
            r_sect_start <= n_sect_start;
            r_sect_step  <= n_sect_step;
            r_sect_span  <= n_sect_span;
            r_sect_type  <= n_sect_type;
            r_field_a    <= n_field_a;
            r_field_b    <= n_field_b;
            r_field_c    <= n_field_c;
        end
    end

endmodule

// ----- design/wiggle_section_decoder_top.sv -----
// ----------------------------------------------------------------------------
// wiggle_section_decoder_top
// Streaming decoder for one uncompressed wiggle data block, fed byte by byte.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle while the skid register is empty: each
// byte is captured in an input register, decoded there by the parse logic,
// and any result is registered in the output register. A one-entry skid
// register behind the output register keeps input flowing while a finished
// result waits; the input only stalls when both the output and skid registers
// are full. Results appear only for bytes that complete an overlapping
// interval or for the block's last byte (tlast). Query registers are written
// through the plain write port; the user must write them only while the block
// is idle, which the block does not enforce; unused indexes are ignored.
module wiggle_section_decoder_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // configuration write port
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_addr,
    input  logic [31:0]   i_cfg_wdata,
    // byte input
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [7:0]    s_axis_tdata,   // [7:0] data_byte
    input  logic          s_axis_tlast,   // last_byte
    // result output
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // [48:0] interval_start, [97:49] interval_end, [129:98] value_bits,
    // [131:130] status, [163:132] reported_count, [167:164] zero
    output logic [167:0]  m_axis_tdata,
    output logic          m_axis_tlast,   // block_done
    output logic          m_axis_tuser    // has_interval
);
    import wsd_pkg::*;

    t_query  r_query;
    logic    r_in_valid;
    logic [7:0] r_in_byte;
    logic    r_in_last;
    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;

    logic    proc_fire;
    logic    out_take;
    logic    res_valid;
    t_result res;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_query <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_QUERY_CHROM: r_query.chrom <= i_cfg_wdata;
                REG_QUERY_START: r_query.start <= i_cfg_wdata;
                REG_QUERY_END:   r_query.stop  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Handshake
    assign proc_fire     = r_in_valid && !r_skid_valid;
    assign s_axis_tready = !r_in_valid || proc_fire;
    assign out_take      = r_out_valid && m_axis_tready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (proc_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    // Decode
    wsd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (proc_fire),
        .i_byte      (r_in_byte),
        .i_last      (r_in_last),
        .i_query     (r_query),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Output register and skid register: valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (res_valid) begin
            if (!r_out_valid || out_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register and skid register: payload
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (res_valid) begin
            if (!r_out_valid || out_take) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out.block_done;
    assign m_axis_tuser  = r_out.has_interval;
    assign m_axis_tdata  = {4'b0000, r_out.reported_count, r_out.status,
                            r_out.value_bits, r_out.interval_end,
                            r_out.interval_start};

    // Skid entry only exists behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a result while output register is empty");

    // Input stalls only when both result registers are occupied
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_valid && r_skid_valid && r_out_valid))
        else $error("input stalled without a full output path");

    // Status code is one of the defined codes
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_out.status == ST_OK || r_out.status == ST_TRUNCATED ||
                           r_out.status == ST_BAD_TYPE))
        else $error("undefined status code on output");

    // Results without an interval carry zero coordinates and value and end the block
    a_no_interval_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !r_out.has_interval) |->
            (r_out.interval_start == '0 && r_out.interval_end == '0 &&
             r_out.value_bits == '0 && r_out.block_done))
        else $error("empty result with nonzero payload or without block end");

    // A stalled result stays put in the output register
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> (r_out_valid && $stable(r_out)))
        else $error("output register changed while stalled");

endmodule
